// ===== rtl/rapqt_pkg.sv =====
// shared types and constants for the range add / point query tree
// packet and control structs passed along the row of level cells
// no dependencies
`timescale 1ns / 1ps

package rapqt_pkg;

   localparam int POS_W      = 11;
   localparam int NODE_W     = 12;
   localparam int DATA_W     = 32;
   localparam int SLOTS      = 4;
   localparam int SLOT_W     = 2;
   localparam int SIZE_LIMIT = (1 << POS_W) - 1;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic REG_SIZE_IN_USE = 1'b0;

   localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(1024);

   typedef enum logic [3:0] {
      PH_READ = 4'b0001,
      PH_WR0  = 4'b0010,
      PH_WR1  = 4'b0100,
      PH_HOLD = 4'b1000
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
      logic [POS_W-1:0]  seg_lo;
      logic [POS_W-1:0]  seg_hi;
   } cand_type;

   typedef struct packed {
      logic                   cmd;
      logic [POS_W-1:0]       key_lo;
      logic [POS_W-1:0]       key_hi;
      logic [DATA_W-1:0]      addend;
      logic                   has_result;
      logic [DATA_W-1:0]      total;
      logic                   out_of_range;
      cand_type [SLOTS-1:0]   cands;
   } packet_type;

   typedef struct packed {
      logic              clearing;
      logic [NODE_W-1:0] clear_addr;
      logic              read_en;
      logic              wr0_en;
      logic              wr1_en;
      logic              advance;
   } ctrl_type;

endpackage

// ===== rtl/rapqt_if.sv =====
// request and response channel interfaces of the range add / point query tree
// depends on rapqt_pkg
`timescale 1ns / 1ps

interface rapqt_req_if;
   import rapqt_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [POS_W-1:0]         first;
   logic [POS_W-1:0]         last;
   logic signed [DATA_W-1:0] amount;
   logic [POS_W-1:0]         position;

   modport source (output valid, command, first, last, amount, position, input ready);
   modport sink   (input valid, command, first, last, amount, position, output ready);
endinterface

interface rapqt_rsp_if;
   import rapqt_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] total;
   logic                     out_of_range;

   modport source (output valid, total, out_of_range, input ready);
   modport sink   (input valid, total, out_of_range, output ready);
endinterface

// ===== rtl/rapqt_ctrl.sv =====
// beat sequencer and reset clearing counter shared by all level cells
// depends on rapqt_pkg
`timescale 1ns / 1ps

module rapqt_ctrl #(
   parameter int CLEAR_W = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   output rapqt_pkg::ctrl_type ctrl
);
   import rapqt_pkg::*;

   localparam logic [CLEAR_W-1:0] CLEAR_LAST = {CLEAR_W{1'b1}};

   phase_type          phase_ff, phase_in;
   logic               clearing_ff, clearing_in;
   logic [CLEAR_W-1:0] clear_cnt_ff, clear_cnt_in;

   always_comb begin
      clearing_in  = clearing_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clearing_ff) begin
         clear_cnt_in = clear_cnt_ff + CLEAR_W'(1);
         if (clear_cnt_ff == CLEAR_LAST) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (!clearing_ff) begin
         case (phase_ff)
            PH_READ: begin
               phase_in = PH_WR0;
            end
            PH_WR0: begin
               phase_in = PH_WR1;
            end
            PH_WR1: begin
               phase_in = go ? PH_READ : PH_HOLD;
            end
            PH_HOLD: begin
               phase_in = go ? PH_READ : PH_HOLD;
            end
            default: begin
               phase_in = PH_READ;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_READ;
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         clearing_ff  <= clearing_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   always_comb begin
      ctrl.clearing   = clearing_ff;
      ctrl.clear_addr = NODE_W'(clear_cnt_ff);
      ctrl.read_en    = !clearing_ff && (phase_ff == PH_READ);
      ctrl.wr0_en     = !clearing_ff && (phase_ff == PH_WR0);
      ctrl.wr1_en     = !clearing_ff && (phase_ff == PH_WR1);
      ctrl.advance    = !clearing_ff && go &&
                        ((phase_ff == PH_WR1) || (phase_ff == PH_HOLD));
   end

endmodule

// ===== rtl/rapqt_cell.sv =====
// one tree level: tag memory for the nodes of that depth and the update logic
// for the transaction passing through; hands child nodes to the next level
// depends on rapqt_pkg
`timescale 1ns / 1ps

module rapqt_cell #(
   parameter int LEVEL = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rapqt_pkg::ctrl_type   ctrl,
   input  rapqt_pkg::packet_type prev_pkt,
   output rapqt_pkg::packet_type next_pkt
);
   import rapqt_pkg::*;

   localparam int ADDR_W = (LEVEL == 0) ? 1 : LEVEL;
   localparam int DEPTH  = 1 << ADDR_W;

   function automatic logic [POS_W-1:0] mid_of(cand_type parent);
      logic [POS_W:0] span;
      span = {1'b0, parent.seg_lo} + {1'b0, parent.seg_hi};
      return span[POS_W:1];
   endfunction

   function automatic cand_type child_of(cand_type parent, logic right);
      logic [POS_W-1:0] mid;
      cand_type         c;
      mid     = mid_of(parent);
      c.valid = 1'b1;
      if (right) begin
         c.node   = {parent.node[NODE_W-2:0], 1'b1};
         c.seg_lo = mid + POS_W'(1);
         c.seg_hi = parent.seg_hi;
      end else begin
         c.node   = {parent.node[NODE_W-2:0], 1'b0};
         c.seg_lo = parent.seg_lo;
         c.seg_hi = mid;
      end
      return c;
   endfunction

   logic [DATA_W-1:0] tags [DEPTH];

   packet_type        pkt_ff, pkt_in;
   logic [DATA_W-1:0] rd0_ff, rd1_ff;

   logic              is_query, leaf0, go_right;
   logic [SLOTS-1:0]  hit_all, hit_part, need_wr;
   logic              op0_v, op1_v, pa_v, pb_v;
   logic [SLOT_W-1:0] op0_i, op1_i, pa_i, pb_i;
   cand_type          op0_c, op1_c, pa_c, pb_c;
   logic [ADDR_W-1:0] rd0_a, rd1_a, mem_wa;
   logic [DATA_W-1:0] sum0, sum1, wr0_data, mem_wd;
   logic              mem_we;

   // classify candidate nodes against the key range and mark those that need a tag write
   always_comb begin
      is_query = (pkt_ff.cmd == CMD_QUERY);
      for (int i = 0; i < SLOTS; i++) begin
         hit_all[i]  = pkt_ff.cands[i].valid &&
                       (pkt_ff.key_lo <= pkt_ff.cands[i].seg_lo) &&
                       (pkt_ff.cands[i].seg_hi <= pkt_ff.key_hi);
         hit_part[i] = pkt_ff.cands[i].valid && !hit_all[i] &&
                       !(pkt_ff.cands[i].seg_hi < pkt_ff.key_lo) &&
                       !(pkt_ff.key_hi < pkt_ff.cands[i].seg_lo);
         need_wr[i]  = is_query ? pkt_ff.cands[i].valid : hit_all[i];
      end
   end

   // pick up to two writes and up to two nodes to split
   always_comb begin
      op0_v = 1'b0;
      op1_v = 1'b0;
      pa_v  = 1'b0;
      pb_v  = 1'b0;
      op0_i = '0;
      op1_i = '0;
      pa_i  = '0;
      pb_i  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (need_wr[i]) begin
            if (!op0_v) begin
               op0_v = 1'b1;
               op0_i = SLOT_W'(i);
            end else if (!op1_v) begin
               op1_v = 1'b1;
               op1_i = SLOT_W'(i);
            end
         end
         if (hit_part[i]) begin
            if (!pa_v) begin
               pa_v = 1'b1;
               pa_i = SLOT_W'(i);
            end else if (!pb_v) begin
               pb_v = 1'b1;
               pb_i = SLOT_W'(i);
            end
         end
      end
      op0_c = pkt_ff.cands[op0_i];
      op1_c = pkt_ff.cands[op1_i];
      pa_c  = pkt_ff.cands[pa_i];
      pb_c  = pkt_ff.cands[pb_i];
   end

   // read-modify-write port control
   always_comb begin
      rd0_a    = op0_c.node[ADDR_W-1:0];
      rd1_a    = op1_c.node[ADDR_W-1:0];
      sum0     = rd0_ff + pkt_ff.addend;
      sum1     = rd1_ff + pkt_ff.addend;
      leaf0    = (pkt_ff.cands[0].seg_lo == pkt_ff.cands[0].seg_hi);
      wr0_data = (is_query && !leaf0) ? '0 : sum0;
      mem_we   = 1'b0;
      mem_wa   = rd0_a;
      mem_wd   = wr0_data;
      if (ctrl.clearing) begin
         mem_we = 1'b1;
         mem_wa = ctrl.clear_addr[ADDR_W-1:0];
         mem_wd = '0;
      end else if (ctrl.wr0_en && op0_v) begin
         mem_we = 1'b1;
      end else if (ctrl.wr1_en && op1_v) begin
         mem_we = 1'b1;
         mem_wa = rd1_a;
         mem_wd = sum1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tags[mem_wa] <= mem_wd;
      end
      if (ctrl.read_en) begin
         rd0_ff <= tags[rd0_a];
         rd1_ff <= tags[rd1_a];
      end
   end

   // transaction handed to the next level
   always_comb begin
      next_pkt       = pkt_ff;
      next_pkt.cands = '0;
      go_right       = (pkt_ff.key_lo > mid_of(pkt_ff.cands[0]));
      if (is_query) begin
         if (pkt_ff.cands[0].valid) begin
            if (leaf0) begin
               next_pkt.has_result   = 1'b1;
               next_pkt.total        = sum0;
               next_pkt.out_of_range = 1'b0;
            end else begin
               next_pkt.addend   = sum0;
               next_pkt.cands[0] = child_of(pkt_ff.cands[0], go_right);
               next_pkt.cands[1] = child_of(pkt_ff.cands[0], !go_right);
            end
         end
      end else begin
         if (pa_v) begin
            next_pkt.cands[0] = child_of(pa_c, 1'b0);
            next_pkt.cands[1] = child_of(pa_c, 1'b1);
         end
         if (pb_v) begin
            next_pkt.cands[2] = child_of(pb_c, 1'b0);
            next_pkt.cands[3] = child_of(pb_c, 1'b1);
         end
      end
   end

   assign pkt_in = ctrl.advance ? prev_pkt : pkt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff <= '0;
      end else begin
         pkt_ff <= pkt_in;
      end
   end

endmodule

// ===== rtl/range_add_point_query_tree.sv =====
// range add / point query tree: one cell per tree level, one transaction per cell
// each transaction takes a read beat and two write beats on each level's single-write
// tag memory; the whole row holds while a response waits
// a request waits in the input register until the row advances, then passes through the
// clog2(MAX_N)+1 levels (MAX_N is CAPACITY capped at 2047); results load the response register
// reset: synchronous; tags then cleared, no request taken
`timescale 1ns / 1ps

module range_add_point_query_tree #(
   parameter int CAPACITY = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   rapqt_req_if.sink                           req_bus,
   rapqt_rsp_if.source                         rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rapqt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rapqt_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rapqt_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);
   import rapqt_pkg::*;

   localparam int MAX_N   = (CAPACITY < SIZE_LIMIT) ? CAPACITY : SIZE_LIMIT;
   localparam int LEVELS  = $clog2(MAX_N) + 1;
   localparam int CLEAR_W = LEVELS - 1;
   localparam logic [POS_W-1:0] MAX_N_P = POS_W'(MAX_N);

   ctrl_type          seq;
   logic              go;

   logic [POS_W-1:0]  size_ff, size_in;
   logic [POS_W-1:0]  n_eff;

   logic              in_valid_ff, in_valid_in;
   logic              in_cmd_ff;
   logic [POS_W-1:0]  in_first_ff, in_last_ff, in_pos_ff;
   logic [DATA_W-1:0] in_amount_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_total_ff;
   logic              rsp_oor_ff;

   logic [POS_W-1:0]  clip_lo, clip_hi;
   packet_type        inj_pkt;
   packet_type        chain [LEVELS+1];
   packet_type        tail;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[CSR_IDX_BIT] == REG_SIZE_IN_USE) ? CSR_DATA_W'(size_ff) : '0;

   always_comb begin
      size_in = size_ff;
      if (psel && penable && pwrite && pready && (paddr[CSR_IDX_BIT] == REG_SIZE_IN_USE)) begin
         size_in = pwdata[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   assign n_eff = (size_ff < MAX_N_P) ? size_ff : MAX_N_P;

   // input register
   assign req_bus.ready = !in_valid_ff && !seq.clearing;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
      end else if (seq.advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_cmd_ff    <= req_bus.command;
         in_first_ff  <= req_bus.first;
         in_last_ff   <= req_bus.last;
         in_amount_ff <= req_bus.amount;
         in_pos_ff    <= req_bus.position;
      end
   end

   // transaction entering the root level
   always_comb begin
      clip_lo = (in_first_ff == '0) ? POS_W'(1) : in_first_ff;
      clip_hi = (in_last_ff > n_eff) ? n_eff : in_last_ff;
      inj_pkt = '0;
      if (in_valid_ff) begin
         inj_pkt.cmd = in_cmd_ff;
         if (in_cmd_ff == CMD_ADD) begin
            inj_pkt.key_lo = clip_lo;
            inj_pkt.key_hi = clip_hi;
            inj_pkt.addend = in_amount_ff;
            if ((n_eff != '0) && (clip_lo <= clip_hi)) begin
               inj_pkt.cands[0].valid  = 1'b1;
               inj_pkt.cands[0].node   = NODE_W'(1);
               inj_pkt.cands[0].seg_lo = POS_W'(1);
               inj_pkt.cands[0].seg_hi = n_eff;
            end
         end else begin
            inj_pkt.key_lo = in_pos_ff;
            inj_pkt.key_hi = in_pos_ff;
            if ((in_pos_ff == '0) || (in_pos_ff > n_eff)) begin
               inj_pkt.has_result   = 1'b1;
               inj_pkt.out_of_range = 1'b1;
            end else begin
               inj_pkt.cands[0].valid  = 1'b1;
               inj_pkt.cands[0].node   = NODE_W'(1);
               inj_pkt.cands[0].seg_lo = POS_W'(1);
               inj_pkt.cands[0].seg_hi = n_eff;
            end
         end
      end
   end

   assign chain[0] = inj_pkt;

   for (genvar d = 0; d < LEVELS; d++) begin : g_level
      rapqt_cell #(
         .LEVEL (d)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (seq),
         .prev_pkt (chain[d]),
         .next_pkt (chain[d+1])
      );
   end

   assign tail = chain[LEVELS];
   assign go   = !(tail.has_result && rsp_valid_ff && !rsp_bus.ready);

   rapqt_ctrl #(
      .CLEAR_W (CLEAR_W)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .ctrl  (seq)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq.advance && tail.has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq.advance && tail.has_result) begin
         rsp_total_ff <= tail.total;
         rsp_oor_ff   <= tail.out_of_range;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.total        = rsp_total_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq.advance && tail.has_result |-> !rsp_valid_ff || rsp_bus.ready)
      else $error("result loaded over a pending response");

   a_rsp_leaves_on_handshake: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_bus.ready))
      else $error("response dropped without handshake");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      seq.clearing |-> !req_bus.ready && !seq.advance)
      else $error("request path active during tag clearing");

   a_oor_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oor_ff |-> rsp_total_ff == '0)
      else $error("out of range response with nonzero total");

endmodule
